// ===== rtl/assert_macros.svh =====
// Assertion macros used by the output register module of the downmix formatter.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Consequent that must hold in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/pcmdm_pkg.sv =====
// Package with the shared types, constants and reciprocal table of the downmix formatter.
package pcmdm_pkg;

  localparam int NUM_INPUTS   = 8;
  localparam int SAMPLE_W     = 24;
  localparam int PAIR_W       = SAMPLE_W + 1;
  localparam int SUM_W        = SAMPLE_W + 3;
  localparam int RECIP_SHIFT  = 30;
  localparam int RECIP_W      = RECIP_SHIFT + 1;
  localparam int PROD_W       = SUM_W + RECIP_W;
  localparam int DEF_MAX_CHANNELS = 8;

  localparam logic [SAMPLE_W-1:0] OFFSET_24 = 24'h800000;
  localparam logic [7:0]          SIGN_FLIP = 8'd128;

  // Output format codes.
  localparam logic FMT_U8    = 1'b0;
  localparam logic FMT_S16LE = 1'b1;

  // Register indexes on the configuration port.
  localparam logic REG_OUTPUT_FORMAT = 1'b0;
  localparam logic REG_CHANNEL_COUNT = 1'b1;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic signed [PAIR_W-1:0]   pair_t;

  typedef struct packed {
    logic       fmt;
    logic [3:0] nchan;
  } cfg_t;

  typedef struct packed {
    logic             neg;
    logic [SUM_W-1:0] mag;
  } sum_t;

  typedef struct packed {
    logic                neg;
    logic [SAMPLE_W-1:0] quo;
  } quo_t;

  // ceil(2^30 / n); exact floor division for magnitudes below 2^27.
  function automatic logic [RECIP_W-1:0] recip(input logic [3:0] n);
    logic [RECIP_W-1:0] r;
    case (n)
      4'd2:    r = 31'd536870912;
      4'd3:    r = 31'd357913942;
      4'd4:    r = 31'd268435456;
      4'd5:    r = 31'd214748365;
      4'd6:    r = 31'd178956971;
      4'd7:    r = 31'd153391690;
      4'd8:    r = 31'd134217728;
      default: r = 31'd1073741824;
    endcase
    return r;
  endfunction

endpackage

// ===== rtl/pcmdm_cfg.sv =====
// Configuration registers with APB-style access and channel count clamping.
module pcmdm_cfg
  import pcmdm_pkg::*;
#(
  parameter int MAX_CHANNELS = DEF_MAX_CHANNELS
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output cfg_t        cfg
);

  localparam logic [3:0] LIM = 4'(MAX_CHANNELS);

  logic       output_format;
  logic [3:0] channel_count;
  logic       wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      output_format <= FMT_S16LE;
      channel_count <= 4'd1;
    end else if (wr_en) begin
      case (paddr[2])
        REG_OUTPUT_FORMAT: output_format <= pwdata[0];
        REG_CHANNEL_COUNT: channel_count <= pwdata[3:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_OUTPUT_FORMAT: prdata = {31'd0, output_format};
      REG_CHANNEL_COUNT: prdata = {28'd0, channel_count};
      default:           prdata = 32'd0;
    endcase
  end

  // A zero count means channel 0 alone; larger counts saturate.
  always_comb begin
    cfg.fmt = output_format;
    if (channel_count == 4'd0) begin
      cfg.nchan = 4'd1;
    end else if (channel_count > LIM) begin
      cfg.nchan = LIM;
    end else begin
      cfg.nchan = channel_count;
    end
  end

endmodule

// ===== rtl/pcmdm_sum.sv =====
// Two-stage adder tree over the active channels, ending in sign and magnitude.
module pcmdm_sum
  import pcmdm_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic [3:0] nchan,
  input  logic    in_valid,
  output logic    in_ready,
  input  sample_t samples [NUM_INPUTS],
  output logic    dn_valid,
  input  logic    dn_ready,
  output sum_t    dn_data
);

  localparam int NUM_PAIRS = NUM_INPUTS / 2;

  logic    v1;
  logic    v2;
  logic    s2_free;
  pair_t   pairs      [NUM_PAIRS];
  pair_t   pairs_next [NUM_PAIRS];
  sample_t act        [NUM_INPUTS];
  logic signed [SUM_W-1:0] total;
  sum_t    sum_next;

  assign s2_free  = !v2 || dn_ready;
  assign in_ready = !v1 || s2_free;
  assign dn_valid = v2;

  always_comb begin
    for (int i = 0; i < NUM_INPUTS; i++) begin
      act[i] = (4'(i) < nchan) ? samples[i] : '0;
    end
    for (int j = 0; j < NUM_PAIRS; j++) begin
      pairs_next[j] = PAIR_W'(act[2*j]) + PAIR_W'(act[2*j+1]);
    end
  end

  always_comb begin
    total = SUM_W'(pairs[0]) + SUM_W'(pairs[1]) + SUM_W'(pairs[2]) + SUM_W'(pairs[3]);
    sum_next.neg = total[SUM_W-1];
    sum_next.mag = total[SUM_W-1] ? SUM_W'(-total) : SUM_W'(total);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      if (s2_free) begin
        v2 <= v1;
      end
      if (in_ready) begin
        v1 <= in_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      pairs <= pairs_next;
    end
    if (s2_free && v1) begin
      dn_data <= sum_next;
    end
  end

endmodule

// ===== rtl/pcmdm_div.sv =====
// Division of the channel sum by the channel count through a reciprocal multiply.
module pcmdm_div
  import pcmdm_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic [3:0] nchan,
  input  logic       up_valid,
  output logic       up_ready,
  input  sum_t       up_data,
  output logic       dn_valid,
  input  logic       dn_ready,
  output quo_t       dn_data
);

  logic              v3;
  logic [PROD_W-1:0] prod;

  assign up_ready = !v3 || dn_ready;
  assign dn_valid = v3;
  assign prod     = PROD_W'(up_data.mag) * PROD_W'(recip(nchan));

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (up_ready) begin
      v3 <= up_valid;
    end
  end

  // The quotient magnitude never exceeds 2^23, so 24 bits hold it.
  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      dn_data.neg <= up_data.neg;
      dn_data.quo <= prod[RECIP_SHIFT +: SAMPLE_W];
    end
  end

endmodule

// ===== rtl/pcmdm_ser.sv =====
// Output register that formats the average and sends one or two PCM bytes.
module pcmdm_ser
  import pcmdm_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       fmt,
  input  logic       in_valid,
  output logic       in_ready,
  input  quo_t       in_data,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] pcm_byte,
  output logic       frame_end
);

`include "assert_macros.svh"

  logic [SAMPLE_W-1:0] avg;
  logic [SAMPLE_W-1:0] biased;
  logic [7:0]          hi_byte;
  logic                out_xfer;
  logic                send_hi;

  assign out_xfer = out_valid && !out_stall;
  // A byte without the frame end flag always has a high byte behind it.
  assign send_hi  = out_xfer && !frame_end;
  assign in_ready = !out_valid || (out_xfer && frame_end);

  assign avg    = in_data.neg ? SAMPLE_W'(-in_data.quo) : in_data.quo;
  assign biased = avg ^ OFFSET_24;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (send_hi) begin
      pcm_byte  <= hi_byte;
      frame_end <= 1'b1;
    end else if (in_ready && in_valid) begin
      case (fmt)
        FMT_U8: begin
          pcm_byte  <= biased[23:16];
          frame_end <= 1'b1;
        end
        FMT_S16LE: begin
          pcm_byte  <= biased[15:8];
          frame_end <= 1'b0;
        end
        default: begin
          pcm_byte  <= biased[23:16];
          frame_end <= 1'b1;
        end
      endcase
      hi_byte <= biased[23:16] + SIGN_FLIP;
    end
  end

  `ASSERT_NEXT(a_hi_follows, clk, rst, send_hi, out_valid && frame_end, "high byte did not follow")
  `ASSERT_ALWAYS(a_lo_only_16, clk, rst, !(out_valid && !frame_end) || fmt == FMT_S16LE, "low byte in 8-bit mode")
  `ASSERT_NEXT(a_load_shows, clk, rst, in_valid && in_ready, out_valid, "accepted frame not shown")

endmodule

// ===== rtl/pcm_downmix_playback_format_unit.sv =====
// Top level of the PCM downmix and playback formatter.
// Each transfer on the input channel is one audio frame of eight 24-bit signed samples; the
// first channel_count of them are averaged (truncating toward zero) and sent as PCM bytes on
// the output channel. In 8-bit mode one unsigned byte leaves per frame and a frame can enter
// in every cycle while the output does not stall. In 16-bit mode two bytes leave per frame, low
// byte first, so the single output byte register takes the next frame only as the high byte
// of the current one leaves. There are four register stages: two adder tree stages, one
// reciprocal multiply stage and the output register. The input transfer edge itself loads
// the first of them; the frame then moves through the others in order. The last byte of
// every frame carries frame_end.
// Configuration is written over the APB-style port at byte address 0 (output_format) and 4
// (channel_count) and must only change while no frame is in flight.
module pcm_downmix_playback_format_unit
  import pcmdm_pkg::*;
#(
  parameter int MAX_CHANNELS = DEF_MAX_CHANNELS
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic signed [23:0] chan_sample_0,
  input  logic signed [23:0] chan_sample_1,
  input  logic signed [23:0] chan_sample_2,
  input  logic signed [23:0] chan_sample_3,
  input  logic signed [23:0] chan_sample_4,
  input  logic signed [23:0] chan_sample_5,
  input  logic signed [23:0] chan_sample_6,
  input  logic signed [23:0] chan_sample_7,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  pcm_byte,
  output logic        frame_end
);

  cfg_t    cfg;
  sample_t samples [NUM_INPUTS];
  logic    in_ready;
  logic    sum_valid;
  logic    sum_ready;
  sum_t    sum_data;
  logic    quo_valid;
  logic    quo_ready;
  quo_t    quo_data;

  // Samples are gathered into one lane array for the adder tree.
  assign samples[0] = chan_sample_0;
  assign samples[1] = chan_sample_1;
  assign samples[2] = chan_sample_2;
  assign samples[3] = chan_sample_3;
  assign samples[4] = chan_sample_4;
  assign samples[5] = chan_sample_5;
  assign samples[6] = chan_sample_6;
  assign samples[7] = chan_sample_7;

  // The input side stalls only when the first stage is full and cannot move on.
  assign in_stall = !in_ready;

  pcmdm_cfg #(
    .MAX_CHANNELS(MAX_CHANNELS)
  ) u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Stages one and two: pairwise sums of the active lanes, then the total as sign and
  // magnitude so that the division truncates toward zero.
  pcmdm_sum u_sum (
    .clk      (clk),
    .rst      (rst),
    .nchan    (cfg.nchan),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .samples  (samples),
    .dn_valid (sum_valid),
    .dn_ready (sum_ready),
    .dn_data  (sum_data)
  );

  // Stage three: multiply by the rounded-up reciprocal of the channel count.
  pcmdm_div u_div (
    .clk      (clk),
    .rst      (rst),
    .nchan    (cfg.nchan),
    .up_valid (sum_valid),
    .up_ready (sum_ready),
    .up_data  (sum_data),
    .dn_valid (quo_valid),
    .dn_ready (quo_ready),
    .dn_data  (quo_data)
  );

  // Output register: restores the sign, applies the offset and serializes the bytes.
  pcmdm_ser u_ser (
    .clk       (clk),
    .rst       (rst),
    .fmt       (cfg.fmt),
    .in_valid  (quo_valid),
    .in_ready  (quo_ready),
    .in_data   (quo_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .pcm_byte  (pcm_byte),
    .frame_end (frame_end)
  );

endmodule

// ===== tb/pcm_downmix_playback_format_unit_tb.sv =====
// Self-checking testbench for the PCM downmix and playback formatter.
`timescale 1ns / 100ps

module pcm_downmix_playback_format_unit_tb;
  import pcmdm_pkg::*;

  // One audio frame as it sits on the eight sample ports; element i is channel i.
  typedef logic [NUM_INPUTS-1:0][SAMPLE_W-1:0] frame_t;

  // One output byte as the formatter should present it.
  typedef struct packed {
    logic [7:0] pcm;
    logic       last;
  } pcm_byte_t;

  // Idle modes of the random phases. Each mode sets how often the sender
  // holds back and how often the receiver stalls.
  typedef enum int {
    IDLE_NONE,
    IDLE_SENDER,
    IDLE_RECEIVER,
    IDLE_BOTH
  } idle_mode_t;

  localparam int CLK_HALF      = 5;
  localparam int RESET_CYCLES  = 12;
  localparam int DRAIN_CYCLES  = 8;
  localparam int RANDOM_PHASES = 8;
  localparam int PHASE_FRAMES  = 110;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic signed [23:0] chan_sample_0 = '0;
  logic signed [23:0] chan_sample_1 = '0;
  logic signed [23:0] chan_sample_2 = '0;
  logic signed [23:0] chan_sample_3 = '0;
  logic signed [23:0] chan_sample_4 = '0;
  logic signed [23:0] chan_sample_5 = '0;
  logic signed [23:0] chan_sample_6 = '0;
  logic signed [23:0] chan_sample_7 = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [7:0]  pcm_byte;
  logic        frame_end;

  // Frames waiting to be offered, and bytes predicted but not yet seen.
  frame_t    pending_frames[$];
  pcm_byte_t expected_bytes[$];

  // Mirror of the configuration registers as the block should hold them.
  logic       fmt_cfg = FMT_S16LE;
  logic [3:0] chan_cfg = 4'd1;

  int  send_idle_pct = 0;
  int  recv_stall_pct = 0;
  logic in_taken = 1'b0;
  int  mismatch_count = 0;

  pcm_downmix_playback_format_unit dut (
    .clk           (clk),
    .rst           (rst),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .chan_sample_0 (chan_sample_0),
    .chan_sample_1 (chan_sample_1),
    .chan_sample_2 (chan_sample_2),
    .chan_sample_3 (chan_sample_3),
    .chan_sample_4 (chan_sample_4),
    .chan_sample_5 (chan_sample_5),
    .chan_sample_6 (chan_sample_6),
    .chan_sample_7 (chan_sample_7),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .pcm_byte      (pcm_byte),
    .frame_end     (frame_end)
  );

  always begin
    #CLK_HALF clk = 1'b1;
    #CLK_HALF clk = 1'b0;
  end

  // Works out the bytes one frame must produce under the current settings.
  // A channel count of zero means channel 0 alone, and counts above the
  // channel limit are clamped to it. The sum is divided with truncation
  // toward zero, which is what SystemVerilog's signed division does.
  function automatic void predict_downmix(input frame_t frame);
    int          nchan;
    longint      total;
    longint      avg;
    logic [23:0] biased;
    pcm_byte_t   b;
    nchan = int'(chan_cfg);
    if (nchan < 1) nchan = 1;
    if (nchan > NUM_INPUTS) nchan = NUM_INPUTS;
    total = 0;
    for (int i = 0; i < nchan; i++) begin
      total += longint'(sample_t'(frame[i]));
    end
    avg = total / longint'(nchan);
    biased = 24'(avg + longint'(OFFSET_24));
    if (fmt_cfg == FMT_U8) begin
      // Unsigned 8-bit: the top byte of the offset value ends the frame.
      b.pcm = biased[23:16];
      b.last = 1'b1;
      expected_bytes.push_back(b);
    end else begin
      // Signed 16-bit little endian: low byte, then the high byte with its
      // sign restored by undoing the offset.
      b.pcm = biased[15:8];
      b.last = 1'b0;
      expected_bytes.push_back(b);
      b.pcm = biased[23:16] + SIGN_FLIP;
      b.last = 1'b1;
      expected_bytes.push_back(b);
    end
  endfunction

  // Sample draw that leans on the extremes and on small values near zero,
  // where truncation toward zero differs from flooring.
  function automatic logic [SAMPLE_W-1:0] draw_sample();
    logic [SAMPLE_W-1:0] s;
    case ($urandom_range(0, 9))
      0: s = 24'h7FFFFF;
      1: s = 24'h800000;
      2: s = 24'($urandom_range(0, 15)) - 24'd8;
      default: s = 24'($urandom);
    endcase
    return s;
  endfunction

  // APB write: setup cycle, then access cycle held until pready.
  task automatic write_register(input logic idx, input logic [31:0] value);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    // Only the low bits of each register are kept.
    if (idx == REG_OUTPUT_FORMAT) begin
      fmt_cfg = value[0];
    end else begin
      chan_cfg = value[3:0];
    end
  endtask

  // Writes both registers with random junk in the unused upper bits, so
  // that the block is seen to ignore them.
  task automatic configure(input logic fmt, input logic [3:0] nchan);
    write_register(REG_OUTPUT_FORMAT, {$urandom} & 32'hFFFF_FFFE | {31'd0, fmt});
    write_register(REG_CHANNEL_COUNT, {$urandom} & 32'hFFFF_FFF0 | {28'd0, nchan});
  endtask

  // Waits until every offered frame has been taken and every predicted byte
  // has come out, then lets the pipeline settle before touching registers.
  task automatic wait_drained();
    while (pending_frames.size() != 0 || expected_bytes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_idle(input idle_mode_t mode);
    case (mode)
      IDLE_SENDER: begin
        send_idle_pct = 71;
        recv_stall_pct = 0;
      end
      IDLE_RECEIVER: begin
        send_idle_pct = 0;
        recv_stall_pct = 71;
      end
      IDLE_BOTH: begin
        send_idle_pct = 12;
        recv_stall_pct = 12;
      end
      default: begin
        send_idle_pct = 0;
        recv_stall_pct = 0;
      end
    endcase
  endtask

  // Directed frames: full-scale positive and negative, silence, a lone -1
  // that truncates to zero once averaged with others, alternating extremes,
  // and a mixed negative set whose sum does not divide evenly.
  task automatic queue_directed_frames();
    frame_t f;
    f = {NUM_INPUTS{24'h7FFFFF}};
    pending_frames.push_back(f);
    f = {NUM_INPUTS{24'h800000}};
    pending_frames.push_back(f);
    f = '0;
    pending_frames.push_back(f);
    f = '0;
    f[0] = 24'hFFFFFF;
    pending_frames.push_back(f);
    for (int i = 0; i < NUM_INPUTS; i++) begin
      f[i] = i[0] ? 24'h800000 : 24'h7FFFFF;
    end
    pending_frames.push_back(f);
    f = {24'd3, -24'd4, -24'd1, 24'd1, -24'd5, -24'd2, -24'd2, -24'd3};
    pending_frames.push_back(f);
  endtask

  // Driver. A frame on the port is held until it is taken; a new one is
  // only offered after the previous transfer, and valid is never tied to
  // the stall input.
  always @(negedge clk) begin
    if (!rst) begin
      if (!(in_valid && !in_taken)) begin
        if (pending_frames.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          in_valid <= 1'b1;
          chan_sample_0 <= pending_frames[0][0];
          chan_sample_1 <= pending_frames[0][1];
          chan_sample_2 <= pending_frames[0][2];
          chan_sample_3 <= pending_frames[0][3];
          chan_sample_4 <= pending_frames[0][4];
          chan_sample_5 <= pending_frames[0][5];
          chan_sample_6 <= pending_frames[0][6];
          chan_sample_7 <= pending_frames[0][7];
        end else begin
          in_valid <= 1'b0;
        end
      end
      out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
    end
  end

  // Monitor. Input transfers feed the predictor from what was on the port;
  // output transfers are checked against the oldest predicted byte.
  always @(posedge clk) begin
    pcm_byte_t want;
    if (rst) begin
      in_taken <= 1'b0;
    end else begin
      in_taken <= in_valid && !in_stall;
      if (in_valid && !in_stall) begin
        predict_downmix({chan_sample_7, chan_sample_6, chan_sample_5, chan_sample_4,
                         chan_sample_3, chan_sample_2, chan_sample_1, chan_sample_0});
        if (pending_frames.size() != 0) void'(pending_frames.pop_front());
      end
      if (out_valid && !out_stall) begin
        if (expected_bytes.size() == 0) begin
          mismatch_count++;
          $display("%0t: unexpected byte pcm_byte=%02h frame_end=%0b",
                   $time, pcm_byte, frame_end);
        end else begin
          want = expected_bytes.pop_front();
          if (pcm_byte !== want.pcm) begin
            mismatch_count++;
            $display("%0t: pcm_byte expected %02h actual %02h", $time, want.pcm, pcm_byte);
          end
          if (frame_end !== want.last) begin
            mismatch_count++;
            $display("%0t: frame_end expected %0b actual %0b", $time, want.last, frame_end);
          end
        end
      end
    end
  end

  // Stimulus: directed frames under the reset settings and a few corner
  // settings, then random phases that sweep format, channel count and the
  // idle modes.
  initial begin
    logic [3:0] corner_counts[4];
    frame_t     f;
    logic [3:0] nchan;
    corner_counts = '{4'd8, 4'd1, 4'd15, 4'd0};

    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Reset values: 16-bit output, one channel.
    set_idle(IDLE_NONE);
    queue_directed_frames();
    wait_drained();
    configure(FMT_U8, 4'd8);
    queue_directed_frames();
    wait_drained();
    configure(FMT_S16LE, 4'd0);
    queue_directed_frames();
    wait_drained();
    configure(FMT_U8, 4'd13);
    queue_directed_frames();
    wait_drained();

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      // The first phases hit the channel count extremes, including the
      // zero and oversized counts that the block must clamp.
      nchan = (p < 4) ? corner_counts[p] : 4'($urandom_range(0, 15));
      configure(p[0] ? FMT_S16LE : FMT_U8, nchan);
      set_idle(idle_mode_t'(p % 4));
      for (int k = 0; k < PHASE_FRAMES; k++) begin
        for (int i = 0; i < NUM_INPUTS; i++) begin
          f[i] = draw_sample();
        end
        pending_frames.push_back(f);
      end
      wait_drained();
    end

    set_idle(IDLE_NONE);
    wait_drained();
    if (mismatch_count == 0 && expected_bytes.size() == 0) begin
      $display("[pcm_downmix_playback_format_unit] OK");
    end else begin
      $display("[pcm_downmix_playback_format_unit] ERROR");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run of this stimulus.
  initial begin
    #2000000;
    $display("[pcm_downmix_playback_format_unit] ERROR");
    $finish;
  end

endmodule
